### hdl/vector_tile_geometry_segmenter_defines.svh
// ----------------------------------------------------------------------------
// Vector tile geometry segmenter assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef VECTOR_TILE_GEOMETRY_SEGMENTER_DEFINES_SVH
`define VECTOR_TILE_GEOMETRY_SEGMENTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VTGS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vtgs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define VTGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vtgs assertion failed");

`endif

### hdl/vtgs_pkg.sv
// ----------------------------------------------------------------------------
// Vector tile geometry segmenter package
// Item types, command codes and the zigzag decode shared by the block.
// ----------------------------------------------------------------------------
package vtgs_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = 29;
    localparam int ID_W   = 3;

    localparam logic [ID_W-1:0] CMD_MOVE  = 3'd1;
    localparam logic [ID_W-1:0] CMD_LINE  = 3'd2;
    localparam logic [ID_W-1:0] CMD_CLOSE = 3'd7;

    typedef enum logic [1:0] {
        OP_CMD  = 2'd0,
        OP_MOVE = 2'd1,
        OP_LINE = 2'd2
    } op_t;

    typedef struct packed {
        logic [WORD_W-1:0] geom_word;
        logic              start_feature;
    } geom_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] seg_x0;
        logic signed [WORD_W-1:0] seg_y0;
        logic signed [WORD_W-1:0] seg_x1;
        logic signed [WORD_W-1:0] seg_y1;
    } seg_t;

    typedef struct packed {
        logic hit;
        seg_t seg;
    } seg_result_t;

    function automatic logic [WORD_W-1:0] unzigzag(input logic [WORD_W-1:0] v);
        unzigzag = {1'b0, v[WORD_W-1:1]} ^ {WORD_W{v[0]}};
    endfunction

endpackage

### hdl/vtgs_core.sv
// ----------------------------------------------------------------------------
// Vector tile geometry segmenter core
// Cursor and command state with the combinational decode of one geometry word.
// ----------------------------------------------------------------------------
module vtgs_core
    import vtgs_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  geom_item_t  item,
    output seg_result_t result
);

    logic [COORD_WIDTH-1:0] cursor_x_reg, cursor_x_next;
    logic [COORD_WIDTH-1:0] cursor_y_reg, cursor_y_next;
    logic [COORD_WIDTH-1:0] prev_x_reg, prev_x_next;
    logic [COORD_WIDTH-1:0] prev_y_reg, prev_y_next;
    logic [COORD_WIDTH-1:0] ring_x_reg, ring_x_next;
    logic [COORD_WIDTH-1:0] ring_y_reg, ring_y_next;
    logic [COORD_WIDTH-1:0] held_dx_reg, held_dx_next;
    logic                   have_prev_reg, have_prev_next;
    logic                   half_held_reg, half_held_next;
    op_t                    op_reg, op_next;
    logic [CNT_W-1:0]       pairs_left_reg, pairs_left_next;

    // State as seen by this item: a feature start clears everything first
    logic [COORD_WIDTH-1:0] cur_x, cur_y, prv_x, prv_y, rng_x, rng_y, hld_dx;
    logic                   have_prev, half_held;
    op_t                    op;
    logic [CNT_W-1:0]       pairs_left;

    logic [ID_W-1:0]        cmd_id;
    logic [CNT_W-1:0]       cmd_cnt;
    logic [COORD_WIDTH-1:0] delta;
    logic [COORD_WIDTH-1:0] sum_x, sum_y;
    logic [CNT_W-1:0]       pairs_dec;
    logic                   hit;
    logic [COORD_WIDTH-1:0] x0, y0, x1, y1;

    always_comb
    begin
        if (item.start_feature)
        begin
            cur_x      = '0;
            cur_y      = '0;
            prv_x      = '0;
            prv_y      = '0;
            rng_x      = '0;
            rng_y      = '0;
            hld_dx     = '0;
            have_prev  = 1'b0;
            half_held  = 1'b0;
            op         = OP_CMD;
            pairs_left = '0;
        end
        else
        begin
            cur_x      = cursor_x_reg;
            cur_y      = cursor_y_reg;
            prv_x      = prev_x_reg;
            prv_y      = prev_y_reg;
            rng_x      = ring_x_reg;
            rng_y      = ring_y_reg;
            hld_dx     = held_dx_reg;
            have_prev  = have_prev_reg;
            half_held  = half_held_reg;
            op         = op_reg;
            pairs_left = pairs_left_reg;
        end
    end

    assign cmd_id    = item.geom_word[ID_W-1:0];
    assign cmd_cnt   = item.geom_word[WORD_W-1:ID_W];
    assign delta     = COORD_WIDTH'(unzigzag(item.geom_word));
    assign sum_x     = cur_x + hld_dx;
    assign sum_y     = cur_y + delta;
    assign pairs_dec = pairs_left - CNT_W'(1);

    // Next state
    always_comb
    begin
        cursor_x_next   = cur_x;
        cursor_y_next   = cur_y;
        prev_x_next     = prv_x;
        prev_y_next     = prv_y;
        ring_x_next     = rng_x;
        ring_y_next     = rng_y;
        held_dx_next    = hld_dx;
        have_prev_next  = have_prev;
        half_held_next  = half_held;
        op_next         = op;
        pairs_left_next = pairs_left;

        case (op)
            OP_MOVE, OP_LINE:
            begin
                if (!half_held)
                begin
                    held_dx_next   = delta;
                    half_held_next = 1'b1;
                end
                else
                begin
                    half_held_next  = 1'b0;
                    cursor_x_next   = sum_x;
                    cursor_y_next   = sum_y;
                    pairs_left_next = pairs_dec;
                    if (op == OP_MOVE)
                    begin
                        ring_x_next = sum_x;
                        ring_y_next = sum_y;
                    end
                    prev_x_next    = sum_x;
                    prev_y_next    = sum_y;
                    have_prev_next = 1'b1;
                    if (pairs_dec == '0)
                    begin
                        op_next = OP_CMD;
                    end
                end
            end
            default:
            begin
                case (cmd_id)
                    CMD_MOVE:
                    begin
                        prev_x_next    = cur_x;
                        prev_y_next    = cur_y;
                        ring_x_next    = cur_x;
                        ring_y_next    = cur_y;
                        have_prev_next = 1'b1;
                        if (cmd_cnt != '0)
                        begin
                            op_next         = OP_MOVE;
                            pairs_left_next = cmd_cnt;
                            half_held_next  = 1'b0;
                        end
                    end
                    CMD_LINE:
                    begin
                        if (cmd_cnt != '0)
                        begin
                            op_next         = OP_LINE;
                            pairs_left_next = cmd_cnt;
                            half_held_next  = 1'b0;
                        end
                    end
                    CMD_CLOSE:
                    begin
                        // Close the ring back to the last MoveTo point
                        if (have_prev)
                        begin
                            prev_x_next = rng_x;
                            prev_y_next = rng_y;
                        end
                    end
                    default:
                    begin
                        op_next = OP_CMD;
                    end
                endcase
            end
        endcase
    end

    // Segment output
    always_comb
    begin
        hit = 1'b0;
        x0  = prv_x;
        y0  = prv_y;
        x1  = rng_x;
        y1  = rng_y;

        case (op)
            OP_MOVE, OP_LINE:
            begin
                if (half_held && op == OP_LINE && have_prev)
                begin
                    hit = 1'b1;
                    x1  = sum_x;
                    y1  = sum_y;
                end
            end
            default:
            begin
                if (cmd_id == CMD_CLOSE && have_prev)
                begin
                    hit = 1'b1;
                end
            end
        endcase
    end

    assign result.hit        = hit;
    assign result.seg.seg_x0 = WORD_W'($signed(x0));
    assign result.seg.seg_y0 = WORD_W'($signed(y0));
    assign result.seg.seg_x1 = WORD_W'($signed(x1));
    assign result.seg.seg_y1 = WORD_W'($signed(y1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            ring_x_reg     <= '0;
            ring_y_reg     <= '0;
            held_dx_reg    <= '0;
            have_prev_reg  <= 1'b0;
            half_held_reg  <= 1'b0;
            op_reg         <= OP_CMD;
            pairs_left_reg <= '0;
        end
        else if (step_en)
        begin
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            ring_x_reg     <= ring_x_next;
            ring_y_reg     <= ring_y_next;
            held_dx_reg    <= held_dx_next;
            have_prev_reg  <= have_prev_next;
            half_held_reg  <= half_held_next;
            op_reg         <= op_next;
            pairs_left_reg <= pairs_left_next;
        end
    end

endmodule

### hdl/vector_tile_geometry_segmenter.sv
// Path: an accepted item is held in the input register, and its segment is registered in the output register.
// Throughput: one item per cycle unless stalled; the cursor add in vtgs_core is combinational.
// The input register refills in the same cycle it drains, so the block stalls only
// while a segment waits in the output register.
// Reset: rst_n clears cursor, pending command and both valid flags asynchronously.
// ----------------------------------------------------------------------------
// Vector tile geometry segmenter
// Turns MoveTo/LineTo/ClosePath geometry words into line segments.
// ----------------------------------------------------------------------------
module vector_tile_geometry_segmenter
    import vtgs_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  geom_item_t item,
    output logic       seg_valid,
    input  logic       seg_ready,
    output seg_t       seg
);

    logic        in_valid_reg, in_valid_next;
    geom_item_t  in_item_reg;
    logic        out_valid_reg, out_valid_next;
    seg_t        out_seg_reg;
    logic        fire;
    logic        take;
    seg_result_t result;

    assign fire       = in_valid_reg && (!out_valid_reg || seg_ready);
    assign item_ready = !in_valid_reg || fire;
    assign take       = item_valid && item_ready;

    vtgs_core #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (fire),
        .item    (in_item_reg),
        .result  (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = result.hit;
        end
        else if (seg_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: the input loads on handshake, the output on a step that yields a segment
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg <= item;
        end
        if (fire && result.hit)
        begin
            out_seg_reg <= result.seg;
        end
    end

    assign seg_valid = out_valid_reg;
    assign seg       = out_seg_reg;

endmodule

### hdl/vtgs_checker.sv
// ----------------------------------------------------------------------------
// Vector tile geometry segmenter checker
// Port-level properties of the segmenter, bound onto the top level.
// ----------------------------------------------------------------------------
`include "vector_tile_geometry_segmenter_defines.svh"

module vtgs_checker
    import vtgs_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_ready,
    input geom_item_t item,
    input logic       seg_valid,
    input logic       seg_ready,
    input seg_t       seg
);

    // Hold a stalled segment
    `VTGS_ASSERT_NEXT(a_seg_hold, clk, rst_n, seg_valid && !seg_ready, seg_valid)
    `VTGS_ASSERT_NEXT(a_seg_stable, clk, rst_n, seg_valid && !seg_ready, $stable(seg))

    // An empty output side never blocks the input side
    `VTGS_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !seg_valid, item_ready)

    // A fresh segment comes from an item that passed the input register and the output register without a stall
    `VTGS_ASSERT_IMPL(a_seg_from_item, clk, rst_n, $rose(seg_valid),
        $past(item_valid && item_ready, 2))

endmodule

bind vector_tile_geometry_segmenter vtgs_checker u_vtgs_checker (.*);

### bench/vector_tile_geometry_segmenter_test.sv
// ----------------------------------------------------------------------------
// Vector tile geometry segmenter testbench
// Streams MoveTo/LineTo/ClosePath geometry words into the segmenter, predicts
// every segment with a cycle-free model of the command decoder and cursor,
// and compares each segment that leaves the block against the oldest one
// predicted. Both handshakes idle at random, with bursts that do not idle.
// ----------------------------------------------------------------------------
module vector_tile_geometry_segmenter_test;
    import vtgs_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_ready;
    geom_item_t item;
    logic       seg_valid;
    logic       seg_ready;
    seg_t       seg;

    vector_tile_geometry_segmenter uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .seg_valid  (seg_valid),
        .seg_ready  (seg_ready),
        .seg        (seg)
    );

    // Decoder state as the block should hold it.
    logic [WORD_W-1:0] cur_x, cur_y;
    logic [WORD_W-1:0] last_x, last_y;
    logic [WORD_W-1:0] ring_x, ring_y;
    logic [WORD_W-1:0] held_dx;
    logic [CNT_W-1:0]  pairs_owed;
    logic              have_last;
    logic              dx_held;
    op_t               pend;

    seg_t expected_segs[$];
    seg_t next_seg;

    int max_gap;
    int max_stall;
    int words_sent;
    int words_accepted;
    int segs_matched;
    int fail_count;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("Timeout: %0d segments still expected", expected_segs.size());
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [WORD_W-1:0] zz_decode(input logic [WORD_W-1:0] v);
        return (v >> 1) ^ (32'd0 - {31'd0, v[0]});
    endfunction

    function automatic logic [WORD_W-1:0] zz_encode(input int d);
        return 32'((d <<< 1) ^ (d >>> 31));
    endfunction

    function automatic logic [WORD_W-1:0] cmd_word(input logic [ID_W-1:0] id,
                                                   input logic [CNT_W-1:0] cnt);
        return {cnt, id};
    endfunction

    // Mix small deltas, deltas near the extremes and fully random words.
    function automatic logic [WORD_W-1:0] param_word();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: return $urandom_range(0, 64);
        endcase
    endfunction

    function automatic void clear_geometry();
        cur_x      = '0;
        cur_y      = '0;
        last_x     = '0;
        last_y     = '0;
        ring_x     = '0;
        ring_y     = '0;
        held_dx    = '0;
        pairs_owed = '0;
        have_last  = 1'b0;
        dx_held    = 1'b0;
        pend       = OP_CMD;
    endfunction

    // Advance the decoder by one word; returns 1 when the word closes a segment.
    function automatic bit step_geometry(input geom_item_t it, output seg_t s);
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] dy;
        logic [ID_W-1:0]   id;
        logic [CNT_W-1:0]  cnt;
        bit                hit;
        w   = it.geom_word;
        id  = w[ID_W-1:0];
        cnt = w[WORD_W-1:ID_W];
        hit = 1'b0;
        s   = '0;
        if (it.start_feature)
            clear_geometry();

        if (pend != OP_MOVE && pend != OP_LINE)
        begin
            if (id == CMD_MOVE)
            begin
                last_x    = cur_x;
                last_y    = cur_y;
                ring_x    = cur_x;
                ring_y    = cur_y;
                have_last = 1'b1;
                if (cnt != 0)
                begin
                    pend       = OP_MOVE;
                    pairs_owed = cnt;
                    dx_held    = 1'b0;
                end
            end
            else if (id == CMD_LINE)
            begin
                if (cnt != 0)
                begin
                    pend       = OP_LINE;
                    pairs_owed = cnt;
                    dx_held    = 1'b0;
                end
            end
            else if (id == CMD_CLOSE && have_last)
            begin
                s.seg_x0 = last_x;
                s.seg_y0 = last_y;
                s.seg_x1 = ring_x;
                s.seg_y1 = ring_y;
                last_x   = ring_x;
                last_y   = ring_y;
                hit      = 1'b1;
            end
            return hit;
        end

        if (!dx_held)
        begin
            held_dx = zz_decode(w);
            dx_held = 1'b1;
            return 1'b0;
        end

        dy         = zz_decode(w);
        dx_held    = 1'b0;
        cur_x      = cur_x + held_dx;
        cur_y      = cur_y + dy;
        pairs_owed = pairs_owed - 1'b1;
        if (pend == OP_MOVE)
        begin
            ring_x = cur_x;
            ring_y = cur_y;
        end
        else if (have_last)
        begin
            s.seg_x0 = last_x;
            s.seg_y0 = last_y;
            s.seg_x1 = cur_x;
            s.seg_y1 = cur_y;
            hit      = 1'b1;
        end
        last_x    = cur_x;
        last_y    = cur_y;
        have_last = 1'b1;
        if (pairs_owed == 0)
            pend = OP_CMD;
        return hit;
    endfunction

    task automatic note_failure(input string what, input seg_t want, input seg_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t %s: expected (%0d,%0d)->(%0d,%0d) got (%0d,%0d)->(%0d,%0d)",
                     $time, what, want.seg_x0, want.seg_y0, want.seg_x1, want.seg_y1,
                     got.seg_x0, got.seg_y0, got.seg_x1, got.seg_y1);
    endtask

    task automatic check_segment(input seg_t got);
        seg_t want;
        if (expected_segs.size() == 0)
        begin
            note_failure("segment with none expected", '0, got);
            return;
        end
        want = expected_segs.pop_front();
        if (got.seg_x0 !== want.seg_x0 || got.seg_y0 !== want.seg_y0 ||
            got.seg_x1 !== want.seg_x1 || got.seg_y1 !== want.seg_y1)
            note_failure("segment mismatch", want, got);
        else
            segs_matched++;
    endtask

    // Check the outgoing segment first, then predict from the incoming word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (seg_valid && seg_ready)
                check_segment(seg);
            if (item_valid && item_ready)
            begin
                words_accepted++;
                if (step_geometry(item, next_seg))
                    expected_segs.insert(expected_segs.size(), next_seg);
            end
        end
    end

    // Segment sink: stall a random number of cycles before each segment.
    initial
    begin : seg_sink
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = $urandom_range(0, max_stall);
            if (stall > 0)
            begin
                seg_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            seg_ready <= 1'b1;
            do @(posedge clk); while (!seg_valid);
            @(negedge clk);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input logic [WORD_W-1:0] word, input logic first);
        int         gap;
        geom_item_t nxt;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        nxt.geom_word     = word;
        nxt.start_feature = first;
        item_valid <= 1'b1;
        item       <= nxt;
        do @(posedge clk); while (!item_ready);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic send_feature();
        int               n_cmds;
        int               r;
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] cnt;
        bit               first;
        first  = 1'b1;
        n_cmds = $urandom_range(1, 8);
        repeat (n_cmds)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                id = CMD_MOVE;
            else if (r < 75)
                id = CMD_LINE;
            else if (r < 92)
                id = CMD_CLOSE;
            else
                do id = ID_W'($urandom_range(0, 7));
                while (id == CMD_MOVE || id == CMD_LINE || id == CMD_CLOSE);

            r = $urandom_range(0, 99);
            if (r < 8)
                cnt = '0;
            else if (r < 96)
                cnt = CNT_W'($urandom_range(1, 4));
            else
                cnt = CNT_W'($urandom);

            send_word(cmd_word(id, cnt), first);
            first = 1'b0;
            if ((id == CMD_MOVE || id == CMD_LINE) && cnt != 0)
            begin
                // cut the feature short, possibly in the middle of a pair
                if (cnt > 4 || $urandom_range(0, 19) == 0)
                begin
                    repeat ($urandom_range(0, 5)) send_word(param_word(), 1'b0);
                    return;
                end
                repeat (2 * cnt) send_word(param_word(), 1'b0);
            end
        end
    endtask

    task automatic test_directed();
        logic [ID_W-1:0] id;
        max_gap   = 12;
        max_stall = 12;
        // ring opened at the far corner, then lines that wrap the cursor
        send_word(cmd_word(CMD_MOVE, CNT_W'(1)), 1'b1);
        send_word(32'hFFFF_FFFE, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(cmd_word(CMD_LINE, CNT_W'(2)), 1'b0);
        send_word(zz_encode(1), 1'b0);
        send_word(zz_encode(0), 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hFFFF_FFFE, 1'b0);
        // close with the largest count, which is ignored
        send_word(cmd_word(CMD_CLOSE, '1), 1'b0);
        for (int k = 0; k < 8; k++)
        begin
            id = k[ID_W-1:0];
            if (id != CMD_MOVE && id != CMD_LINE && id != CMD_CLOSE)
                send_word(cmd_word(id, CNT_W'($urandom)), 1'b0);
        end
        send_word(cmd_word(CMD_MOVE, '0), 1'b0);
        send_word(cmd_word(CMD_LINE, '0), 1'b0);
        send_word(cmd_word(CMD_CLOSE, '0), 1'b0);
        // close and line before any point exists: no segment
        send_word(cmd_word(CMD_CLOSE, '0), 1'b1);
        send_word(cmd_word(CMD_LINE, CNT_W'(1)), 1'b1);
        send_word(zz_encode(-7), 1'b0);
        send_word(zz_encode(9), 1'b0);
        // huge count, one pair, then drop a half pair at the feature boundary
        send_word(cmd_word(CMD_LINE, '1), 1'b0);
        send_word(zz_encode(-1), 1'b0);
        send_word(zz_encode(100), 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(cmd_word(CMD_MOVE, '0), 1'b1);
    endtask

    task automatic test_random_geometry(input int n_words, input int gap_max,
                                        input int stall_max);
        int target;
        max_gap   = gap_max;
        max_stall = stall_max;
        target    = words_sent + n_words;
        while (words_sent < target)
            send_feature();
    endtask

    task automatic test_noise(input int n_words);
        max_gap   = 12;
        max_stall = 12;
        repeat (n_words)
            send_word($urandom, $urandom_range(0, 9) == 0);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item           = '0;
        seg_ready      = 1'b0;
        max_gap        = 12;
        max_stall      = 12;
        words_sent     = 0;
        words_accepted = 0;
        segs_matched   = 0;
        fail_count     = 0;
        clear_geometry();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_geometry(600, 12, 12);
        test_random_geometry(400, 0, 0);
        test_random_geometry(350, 0, 12);
        test_random_geometry(350, 12, 0);
        test_noise(250);
        item_valid <= 1'b0;

        while (expected_segs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Streamed %0d geometry words (%0d accepted) across directed, feature and noise runs",
                 words_sent, words_accepted);
        $display("Matched %0d segments, %0d failures", segs_matched, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
